>>> rtl/descriptor_ring_forwarder_defines.svh
// Assertion macros for the file that carries concurrent checks.
// Each macro samples on clk and is disabled while rst is high.
`ifndef DESCRIPTOR_RING_FORWARDER_DEFINES_SVH
`define DESCRIPTOR_RING_FORWARDER_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define DRF_CHECK_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("descriptor_ring_forwarder check failed");

// The consequent must hold in the cycle after the antecedent.
`define DRF_CHECK_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("descriptor_ring_forwarder check failed");

// The expression must hold at every clock edge outside reset.
`define DRF_CHECK_ALWAYS(lbl, expr) \
  lbl: assert property (@(posedge clk) disable iff (rst) (expr)) \
    else $error("descriptor_ring_forwarder check failed");

`endif

>>> rtl/drf_pkg.sv
package drf_pkg;

  localparam int RING_DEPTH_DEF = 16;
  // A forward pass never handles more than this many receive slots.
  localparam int WALK_CAP_MAX = 16;

  typedef enum logic [2:0] {
    FN_LOAD_RX = 3'd0,
    FN_LOAD_TX = 3'd1,
    FN_RX_DONE = 3'd2,
    FN_TX_DONE = 3'd3,
    FN_FORWARD = 3'd4
  } func_t;

  typedef enum logic [1:0] {
    KIND_FWD  = 2'd0,
    KIND_DROP = 2'd1,
    KIND_TAIL = 2'd2,
    KIND_ACK  = 2'd3
  } kind_t;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_WALK = 1'b1
  } state_t;

  typedef struct packed {
    logic capture;
    logic do_event;
    logic walk_start;
    logic walk_step;
    logic emit_tail;
  } cmd_t;

  typedef struct packed {
    logic [2:0] func;
    logic       walk_more;
  } stat_t;

endpackage

>>> rtl/drf_ctrl.sv
module drf_ctrl
  import drf_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  in_valid,
  output logic  in_ready,
  output logic  out_valid,
  input  logic  out_ready,
  input  stat_t stat,
  output cmd_t  cmd
);

  state_t state, state_next;
  logic   pending, pending_next;
  logic   out_valid_r, out_valid_next;
  logic   out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      pending     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state       <= state_next;
      pending     <= pending_next;
      out_valid_r <= out_valid_next;
    end
  end

  always_comb begin
    out_free     = !out_valid_r || out_ready;
    cmd          = '0;
    state_next   = state;
    pending_next = pending;

    // The input register takes a new transaction whenever it is empty.
    cmd.capture = in_valid && !pending;
    if (cmd.capture) begin
      pending_next = 1'b1;
    end

    unique case (state)
      ST_IDLE: begin
        if (pending) begin
          unique case (stat.func)
            FN_LOAD_RX, FN_LOAD_TX, FN_RX_DONE, FN_TX_DONE: begin
              if (out_free) begin
                cmd.do_event = 1'b1;
                pending_next = 1'b0;
              end
            end
            FN_FORWARD: begin
              cmd.walk_start = 1'b1;
              pending_next   = 1'b0;
              state_next     = ST_WALK;
            end
            default: begin
              pending_next = 1'b0;
            end
          endcase
        end
      end
      ST_WALK: begin
        if (out_free) begin
          if (stat.walk_more) begin
            cmd.walk_step = 1'b1;
          end else begin
            cmd.emit_tail = 1'b1;
            state_next    = ST_IDLE;
          end
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase

    if (cmd.do_event || cmd.walk_step || cmd.emit_tail) begin
      out_valid_next = 1'b1;
    end else if (out_ready) begin
      out_valid_next = 1'b0;
    end else begin
      out_valid_next = out_valid_r;
    end
  end

  assign in_ready  = !pending;
  assign out_valid = out_valid_r;

endmodule

>>> rtl/drf_datapath.sv
module drf_datapath
  import drf_pkg::*;
#(
  parameter int RING_DEPTH = RING_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  cmd_t        cmd,
  output stat_t       stat,
  input  logic [2:0]  func,
  input  logic [3:0]  slot,
  input  logic [31:0] buffer_address,
  input  logic [15:0] frame_length,
  output logic [1:0]  kind,
  output logic [3:0]  rx_index,
  output logic [3:0]  tx_index,
  output logic [31:0] tx_buffer,
  output logic [31:0] rx_buffer,
  output logic [15:0] length_out,
  output logic [3:0]  rx_tail,
  output logic [3:0]  tx_tail,
  output logic        last
);

  localparam int IDX_W    = $clog2(RING_DEPTH);
  localparam int WALK_CAP = (RING_DEPTH < WALK_CAP_MAX) ? RING_DEPTH : WALK_CAP_MAX;
  localparam int CNT_W    = $clog2(WALK_CAP + 1);

  function automatic logic [IDX_W-1:0] ptr_inc(input logic [IDX_W-1:0] p);
    return (p == IDX_W'(RING_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  // Held input transaction.
  logic [2:0]  in_func;
  logic [3:0]  in_slot;
  logic [31:0] in_addr;
  logic [15:0] in_len;

  // Ring storage.
  logic [31:0] rx_addr [RING_DEPTH];
  logic [15:0] rx_len  [RING_DEPTH];
  logic [31:0] tx_addr [RING_DEPTH];
  logic [RING_DEPTH-1:0] rx_done;
  logic [RING_DEPTH-1:0] tx_free;

  logic [IDX_W-1:0] rx_ptr;
  logic [IDX_W-1:0] tx_ptr;
  logic [CNT_W-1:0] walk_cnt;

  logic             slot_ok;
  logic [IDX_W-1:0] slot_idx;
  logic [31:0]      r_addr;
  logic [15:0]      r_len;
  logic [31:0]      t_addr;
  logic             t_free;
  logic             r_done;
  logic [IDX_W-1:0] rx_tail_idx;

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      in_func <= func;
      in_slot <= slot;
      in_addr <= buffer_address;
      in_len  <= frame_length;
    end
  end

  assign slot_ok     = 32'(in_slot) < 32'(RING_DEPTH);
  assign slot_idx    = IDX_W'(in_slot);
  assign r_addr      = rx_addr[rx_ptr];
  assign r_len       = rx_len[rx_ptr];
  assign t_addr      = tx_addr[tx_ptr];
  assign t_free      = tx_free[tx_ptr];
  assign r_done      = rx_done[rx_ptr];
  assign rx_tail_idx = (rx_ptr == '0) ? IDX_W'(RING_DEPTH - 1) : rx_ptr - 1'b1;

  assign stat.func      = in_func;
  assign stat.walk_more = (walk_cnt < CNT_W'(WALK_CAP)) && r_done;

  // Address and length stores: event writes and the buffer swap never coincide.
  always_ff @(posedge clk) begin
    if (cmd.do_event && slot_ok) begin
      unique case (in_func)
        FN_LOAD_RX: rx_addr[slot_idx] <= in_addr;
        FN_LOAD_TX: tx_addr[slot_idx] <= in_addr;
        FN_RX_DONE: rx_len[slot_idx]  <= in_len;
        default: ;
      endcase
    end
    if (cmd.walk_step && t_free) begin
      tx_addr[tx_ptr] <= r_addr;
      rx_addr[rx_ptr] <= t_addr;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rx_done  <= '0;
      tx_free  <= '1;
      rx_ptr   <= '0;
      tx_ptr   <= '0;
      walk_cnt <= '0;
    end else begin
      if (cmd.do_event && slot_ok) begin
        unique case (in_func)
          FN_RX_DONE: rx_done[slot_idx] <= 1'b1;
          FN_TX_DONE: tx_free[slot_idx] <= 1'b1;
          default: ;
        endcase
      end
      if (cmd.walk_start) begin
        walk_cnt <= '0;
      end
      if (cmd.walk_step) begin
        walk_cnt        <= walk_cnt + 1'b1;
        rx_done[rx_ptr] <= 1'b0;
        rx_ptr          <= ptr_inc(rx_ptr);
        if (t_free) begin
          tx_free[tx_ptr] <= 1'b0;
          tx_ptr          <= ptr_inc(tx_ptr);
        end
      end
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (cmd.do_event || cmd.walk_step || cmd.emit_tail) begin
      kind       <= KIND_ACK;
      rx_index   <= '0;
      tx_index   <= '0;
      tx_buffer  <= '0;
      rx_buffer  <= '0;
      length_out <= '0;
      rx_tail    <= '0;
      tx_tail    <= '0;
      last       <= 1'b1;
      if (cmd.walk_step) begin
        rx_index <= 4'(rx_ptr);
        tx_index <= 4'(tx_ptr);
        last     <= 1'b0;
        if (t_free) begin
          kind       <= KIND_FWD;
          tx_buffer  <= r_addr;
          rx_buffer  <= t_addr;
          length_out <= r_len;
        end else begin
          kind      <= KIND_DROP;
          rx_buffer <= r_addr;
        end
      end else if (cmd.emit_tail) begin
        kind    <= KIND_TAIL;
        rx_tail <= 4'(rx_tail_idx);
        tx_tail <= 4'(tx_ptr);
      end
    end
  end

endmodule

>>> rtl/descriptor_ring_forwarder.sv
// Descriptor ring forwarder. The block holds a receive ring and a transmit
// ring of RING_DEPTH slots each and forwards received frames to the transmit
// ring without copying data: a forward pass swaps buffer addresses between
// the receive slot at the receive head and the transmit slot at the transmit
// head. Each input transaction is one of five commands: load a receive buffer
// address, load a transmit buffer address, mark a receive slot done with its
// frame length, mark a transmit slot complete (free again), or run a forward
// pass. The four events answer with a single acknowledge result; a slot index
// beyond the ring is acknowledged but changes nothing, and the unused command
// codes are absorbed with no result. A forward pass walks done receive slots
// in order, at most min(RING_DEPTH, 16) of them, giving one forwarded or
// dropped result per slot (dropped when the transmit slot at the head is
// still busy), and ends with a tail-pointer result that carries last = 1.
// An input transaction is first taken into an input register and executed
// from it afterwards; no new one is taken until the held event has run or
// the held forward pass has started. A forward pass starts the walk, handles
// each receive slot in turn and ends with the tail result. The walk moves
// one slot per cycle while the output is free, because every ring store has
// a single read port at each head pointer. The result register lets the
// next transaction be captured while a result is still waiting on the
// output, and output back-pressure simply pauses the walk. There is no
// clearing pass after reset: the done and free flags reset at once, while
// the address and length stores hold whatever was last written.
module descriptor_ring_forwarder
  import drf_pkg::*;
#(
  parameter int RING_DEPTH = RING_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  func,
  input  logic [3:0]  slot,
  input  logic [31:0] buffer_address,
  input  logic [15:0] frame_length,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  kind,
  output logic [3:0]  rx_index,
  output logic [3:0]  tx_index,
  output logic [31:0] tx_buffer,
  output logic [31:0] rx_buffer,
  output logic [15:0] length_out,
  output logic [3:0]  rx_tail,
  output logic [3:0]  tx_tail,
  output logic        last
);

`include "descriptor_ring_forwarder_defines.svh"

  // Commands from the controller and status back from the datapath.
  cmd_t  cmd;
  stat_t stat;

  drf_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  drf_datapath #(
    .RING_DEPTH (RING_DEPTH)
  ) u_datapath (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .stat           (stat),
    .func           (func),
    .slot           (slot),
    .buffer_address (buffer_address),
    .frame_length   (frame_length),
    .kind           (kind),
    .rx_index       (rx_index),
    .tx_index       (tx_index),
    .tx_buffer      (tx_buffer),
    .rx_buffer      (rx_buffer),
    .length_out     (length_out),
    .rx_tail        (rx_tail),
    .tx_tail        (tx_tail),
    .last           (last)
  );

  // Only acknowledge and tail results close a transaction.
  `DRF_CHECK_SAME(a_last_matches_kind, out_valid, last == (kind == KIND_TAIL || kind == KIND_ACK))

  // A captured transaction occupies the input register in the next cycle.
  `DRF_CHECK_NEXT(a_capture_blocks_input, (in_valid && in_ready), !in_ready)

  // At most one result is loaded into the output register per cycle.
  `DRF_CHECK_ALWAYS(a_single_result_load, $onehot0({cmd.do_event, cmd.walk_step, cmd.emit_tail}))

endmodule
